>>> sv/fafd_pkg.sv
// Shared types and constants for the fanning angle pipeline.
package fafd_pkg;

    localparam int ZW = 32;                       // Q.29 angle width
    localparam logic signed [ZW-1:0] PI_Q29      = 32'sd1686629713;
    localparam logic signed [ZW-1:0] HALF_PI_Q29 = 32'sd843314857;
    localparam logic signed [ZW-1:0] INV_GAIN    = 32'sd326016437;
    localparam int TABLE_LEN = 24;
    localparam int PSI_LIMIT = 25736;

    localparam int REG_AXIAL   = 0;
    localparam int REG_AZIMUTH = 1;

    typedef enum logic [1:0] {
        MODE_VEC_PHI = 2'd0,
        MODE_ROT     = 2'd1,
        MODE_VEC_PSI = 2'd2
    } t_mode;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] tab [TABLE_LEN];
        tab = '{32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
                32'sd33510843, 32'sd16771758, 32'sd8387925, 32'sd4194219,
                32'sd2097141, 32'sd1048575, 32'sd524288, 32'sd262144,
                32'sd131072, 32'sd65536, 32'sd32768, 32'sd16384,
                32'sd8192, 32'sd4096, 32'sd2048, 32'sd1024,
                32'sd512, 32'sd256, 32'sd128, 32'sd64};
        return tab[i];
    endfunction

endpackage

>>> sv/fanning_angle_from_directions_top.sv
// Top level: fanning angle per voxel from fibre and fanning directions.
// Usage:
//   s_axis carries one voxel word per handshake; m_axis returns one
//   psi_angle word per voxel, in order.  s_axis tdata, low bit first:
//   in_mask[0], fibre_x, fibre_y, fibre_z, fan_x, fan_y, fan_z (97 bits
//   padded to 104).  m_axis tdata is psi_angle, Q3.13 radians.
//   Throughput is one voxel per cycle unless m_axis stalls.  The pipeline
//   is three chains of CORDIC cells (azimuth, cos/sin, psi) plus the
//   matrix and rounding stages.
//   The whole pipeline advances only while the output register is free or
//   being read, so a stall on m_axis_tready holds every word in place and
//   s_axis_tready follows it.
//   Config: i_cfg_we writes register i_cfg_idx (0 axial, 1 azimuth
//   threshold); write only while the pipe is empty.
//   Reset (synchronous, active low) empties the pipeline and loads both
//   thresholds with 3277.
module fanning_angle_from_directions_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [103:0]  s_axis_tdata,   // in_mask, fibre_x/y/z, fan_x/y/z
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [15:0]   m_axis_tdata,   // psi_angle
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [14:0]   i_cfg_data
);
    import fafd_pkg::*;

    localparam int XW = 56;
    localparam int SW = 67;   // mask, fibre_z, fan xyz, zero-xy flag, zero-v flag

    logic [14:0] r_axial, r_azimuth;
    logic        r_ovld;
    logic [15:0] r_psi;
    logic        w_en;

    assign w_en          = !r_ovld || m_axis_tready;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axial   <= 15'd3277;
            r_azimuth <= 15'd3277;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == 1'(REG_AXIAL)) r_axial <= i_cfg_data;
            else                            r_azimuth <= i_cfg_data;
        end
    end

    logic signed [15:0] w_fx, w_fy, w_fz, w_ax, w_ay, w_az;
    assign w_fx = s_axis_tdata[16:1];
    assign w_fy = s_axis_tdata[32:17];
    assign w_fz = s_axis_tdata[48:33];
    assign w_ax = s_axis_tdata[64:49];
    assign w_ay = s_axis_tdata[80:65];
    assign w_az = s_axis_tdata[96:81];

    // side band: mask, fz, ax, ay, az, zero-xy flag, zero-v flag slot
    logic [SW-1:0] w_side0;
    assign w_side0 = {1'b0, (w_fx == 16'sd0 && w_fy == 16'sd0), w_az, w_ay, w_ax,
                      w_fz, s_axis_tdata[0]};

    // chain 1: azimuth
    logic                 c1_vld;
    logic signed [XW-1:0] c1_x, c1_y;
    logic signed [31:0]   c1_z;
    logic [SW-1:0]        c1_side;
    fafd_chain #(.STEPS(CORDIC_STEPS), .XW(XW), .SW(SW)) u_phi (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_vld(s_axis_tvalid && w_en), .i_rot(1'b0),
        .i_x(XW'(w_fx)), .i_y(XW'(w_fy)), .i_z('0), .i_side(w_side0),
        .o_vld(c1_vld), .o_x(c1_x), .o_y(c1_y), .o_z(c1_z), .o_side(c1_side)
    );

    logic signed [31:0] w_phi;
    assign w_phi = c1_side[65] ? 32'sd0 : c1_z;

    // chain 2: cos/sin
    logic                 c2_vld;
    logic signed [XW-1:0] c2_x, c2_y;
    logic signed [31:0]   c2_z;
    logic [SW-1:0]        c2_side;
    fafd_chain #(.STEPS(CORDIC_STEPS), .XW(XW), .SW(SW)) u_cs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_vld(c1_vld), .i_rot(1'b1),
        .i_x(XW'(INV_GAIN)), .i_y('0), .i_z(w_phi), .i_side(c1_side),
        .o_vld(c2_vld), .o_x(c2_x), .o_y(c2_y), .o_z(c2_z), .o_side(c2_side)
    );

    function automatic logic signed [17:0] rnd_clamp(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] r;
        r = (v + XW'(16'sd8192)) >>> 14;
        if (r > 32768)  return 18'sd32768;
        if (r < -32768) return -18'sd32768;
        return r[17:0];
    endfunction

    // stage A: c, s, products t*c and t*s
    logic               ra_vld;
    logic signed [17:0] ra_c, ra_s;
    logic signed [33:0] ra_tc, ra_ts;
    logic [SW-1:0]      ra_side;
    logic signed [17:0] w_c, w_s;
    logic signed [15:0] w_t;
    assign w_c = rnd_clamp(c2_x);
    assign w_s = rnd_clamp(c2_y);
    assign w_t = c2_side[16:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) ra_vld <= 1'b0;
        else if (w_en) ra_vld <= c2_vld;
        if (w_en) begin
            ra_c <= w_c;
            ra_s <= w_s;
            ra_tc <= 34'(w_t) * 34'(w_c);
            ra_ts <= 34'(w_t) * 34'(w_s);
            ra_side <= c2_side;
        end
    end

    // stage B: build matrix
    logic               rb_vld;
    logic signed [18:0] rb_m11, rb_m12, rb_m21, rb_m22;
    logic signed [15:0] rb_b1, rb_b2;
    logic [SW-1:0]      rb_side;
    logic signed [33:0] w_tcr, w_tsr;
    logic signed [15:0] w_tb, w_ax2, w_ay2, w_az2;
    logic [15:0]        w_abs_t;
    logic [17:0]        w_abs_s;
    assign w_tcr = (ra_tc + 34'sd16384) >>> 15;
    assign w_tsr = (ra_ts + 34'sd16384) >>> 15;
    assign w_tb  = ra_side[16:1];
    assign w_ax2 = ra_side[32:17];
    assign w_ay2 = ra_side[48:33];
    assign w_az2 = ra_side[64:49];
    assign w_abs_t = w_tb[15] ? 16'(-w_tb) : 16'(w_tb);
    assign w_abs_s = ra_s[17] ? 18'(-ra_s) : 18'(ra_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rb_vld <= 1'b0;
        else if (w_en) rb_vld <= ra_vld;
        if (w_en) begin
            rb_side <= ra_side;
            if ((w_tb == -16'sd32768) || (w_abs_t > 16'(r_axial))) begin
                rb_m11 <= -19'(ra_s);  rb_m12 <= -19'(w_tcr);
                rb_m21 <= 19'(ra_c);   rb_m22 <= -19'(w_tsr);
                rb_b1 <= w_ax2; rb_b2 <= w_ay2;
            end else if (w_abs_s > 18'(r_azimuth)) begin
                rb_m11 <= -19'(ra_s);  rb_m12 <= -19'(w_tcr);
                rb_m21 <= '0;          rb_m22 <= 19'(ra_s);
                rb_b1 <= w_ax2; rb_b2 <= w_az2;
            end else begin
                rb_m11 <= 19'(ra_c);   rb_m12 <= -19'(w_tsr);
                rb_m21 <= '0;          rb_m22 <= 19'(ra_s);
                rb_b1 <= w_ay2; rb_b2 <= w_az2;
            end
        end
    end

    // stage C: the six products
    logic               rc_vld;
    logic signed [37:0] rc_p1, rc_p2, rc_p3, rc_p4, rc_p5, rc_p6;
    logic [SW-1:0]      rc_side;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rc_vld <= 1'b0;
        else if (w_en) rc_vld <= rb_vld;
        if (w_en) begin
            rc_side <= rb_side;
            rc_p1 <= 38'(rb_m11) * 38'(rb_m22);
            rc_p2 <= 38'(rb_m12) * 38'(rb_m21);
            rc_p3 <= 38'(rb_m22) * 38'(rb_b1);
            rc_p4 <= 38'(rb_m12) * 38'(rb_b2);
            rc_p5 <= 38'(rb_m11) * 38'(rb_b2);
            rc_p6 <= 38'(rb_m21) * 38'(rb_b1);
        end
    end

    // stage D: determinant sign fix
    logic                 rd_vld;
    logic signed [XW-1:0] rd_v1, rd_v2;
    logic [SW-1:0]        rd_side;
    logic signed [38:0]   w_det, w_v1, w_v2;
    assign w_det = 39'(rc_p1) - 39'(rc_p2);
    assign w_v1  = 39'(rc_p3) - 39'(rc_p4);
    assign w_v2  = 39'(rc_p5) - 39'(rc_p6);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) rd_vld <= 1'b0;
        else if (w_en) rd_vld <= rc_vld;
        if (w_en) begin
            rd_side <= rc_side;
            rd_v1 <= w_det < 0 ? -XW'(w_v1) : XW'(w_v1);
            rd_v2 <= w_det < 0 ? -XW'(w_v2) : XW'(w_v2);
        end
    end

    // chain 3: psi
    logic                 c3_vld;
    logic signed [XW-1:0] c3_x, c3_y;
    logic signed [31:0]   c3_z;
    logic [SW-1:0]        c3_side;
    logic [SW-1:0]        w_side3;
    assign w_side3 = {(rd_v1 == '0 && rd_v2 == '0), rd_side[65:0]};
    fafd_chain #(.STEPS(CORDIC_STEPS), .XW(XW), .SW(SW)) u_psi (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(w_en),
        .i_vld(rd_vld), .i_rot(1'b0),
        .i_x(rd_v1), .i_y(rd_v2), .i_z('0), .i_side(w_side3),
        .o_vld(c3_vld), .o_x(c3_x), .o_y(c3_y), .o_z(c3_z), .o_side(c3_side)
    );

    logic signed [31:0] w_pr;
    logic signed [15:0] w_psi;
    assign w_pr = (c3_z + 32'sd32768) >>> 16;
    always_comb begin
        if (!c3_side[0] || c3_side[66])       w_psi = '0;
        else if (w_pr > PSI_LIMIT)           w_psi = 16'(PSI_LIMIT);
        else if (w_pr < -PSI_LIMIT)          w_psi = -16'(PSI_LIMIT);
        else                                 w_psi = w_pr[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovld <= 1'b0;
        else if (w_en) r_ovld <= c3_vld;
        if (w_en) r_psi <= w_psi;
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_psi;

    logic w_unused;
    assign w_unused = ^{s_axis_tdata[103:97], c1_x, c1_y, c2_z, c3_x, c3_y,
                        c3_side[65:1]};
endmodule

>>> sv/fafd_cell.sv
// One CORDIC micro-rotation cell with a registered output and a sideband.
module fafd_cell #(
    parameter int STEP = 0,
    parameter int XW   = 48,
    parameter int SW   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic                  i_rot,
    input  logic signed [XW-1:0]  i_x,
    input  logic signed [XW-1:0]  i_y,
    input  logic signed [31:0]    i_z,
    input  logic [SW-1:0]         i_side,
    output logic                  o_vld,
    output logic signed [XW-1:0]  o_x,
    output logic signed [XW-1:0]  o_y,
    output logic signed [31:0]    o_z,
    output logic [SW-1:0]         o_side
);
    import fafd_pkg::*;

    logic                 r_vld;
    logic signed [XW-1:0] r_x, r_y, n_x, n_y;
    logic signed [31:0]   r_z, n_z;
    logic [SW-1:0]        r_side;
    logic                 w_pos;

    always_comb begin
        w_pos = i_rot ? (i_z >= 0) : (i_y <= 0);
        if (w_pos) begin
            n_x = i_x - (i_y >>> STEP);
            n_y = i_y + (i_x >>> STEP);
        end else begin
            n_x = i_x + (i_y >>> STEP);
            n_y = i_y - (i_x >>> STEP);
        end
        n_z = w_pos ? i_z - atan_entry(STEP) : i_z + atan_entry(STEP);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;
    assign o_side = r_side;
endmodule

>>> sv/fafd_chain.sv
// A row of CORDIC cells with pre-rotation in front.
module fafd_chain #(
    parameter int STEPS = 16,
    parameter int XW    = 48,
    parameter int SW    = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  logic                  i_rot,
    input  logic signed [XW-1:0]  i_x,
    input  logic signed [XW-1:0]  i_y,
    input  logic signed [31:0]    i_z,
    input  logic [SW-1:0]         i_side,
    output logic                  o_vld,
    output logic signed [XW-1:0]  o_x,
    output logic signed [XW-1:0]  o_y,
    output logic signed [31:0]    o_z,
    output logic [SW-1:0]         o_side
);
    import fafd_pkg::*;

    logic                 w_vld  [STEPS+1];
    logic signed [XW-1:0] w_x    [STEPS+1];
    logic signed [XW-1:0] w_y    [STEPS+1];
    logic signed [31:0]   w_z    [STEPS+1];
    logic [SW-1:0]        w_side [STEPS+1];

    // quadrant fold ahead of the first cell
    always_comb begin
        w_vld[0]  = i_vld;
        w_side[0] = i_side;
        w_x[0] = i_x;
        w_y[0] = i_y;
        w_z[0] = i_z;
        if (i_rot) begin
            if (i_z > HALF_PI_Q29) begin
                w_x[0] = -i_x;
                w_z[0] = i_z - PI_Q29;
            end else if (i_z < -HALF_PI_Q29) begin
                w_x[0] = -i_x;
                w_z[0] = i_z + PI_Q29;
            end
        end else if (i_x < 0) begin
            w_x[0] = -i_x;
            w_y[0] = -i_y;
            w_z[0] = (i_y >= 0) ? PI_Q29 : -PI_Q29;
        end else begin
            w_z[0] = '0;
        end
    end

    logic r_rot [STEPS+1];
    assign r_rot[0] = i_rot;

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        fafd_cell #(.STEP(g), .XW(XW), .SW(SW)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(i_en),
            .i_vld(w_vld[g]), .i_rot(r_rot[g]),
            .i_x(w_x[g]), .i_y(w_y[g]), .i_z(w_z[g]), .i_side(w_side[g]),
            .o_vld(w_vld[g+1]), .o_x(w_x[g+1]), .o_y(w_y[g+1]),
            .o_z(w_z[g+1]), .o_side(w_side[g+1])
        );
        assign r_rot[g+1] = i_rot;
    end

    assign o_vld  = w_vld[STEPS];
    assign o_x    = w_x[STEPS];
    assign o_y    = w_y[STEPS];
    assign o_z    = w_z[STEPS];
    assign o_side = w_side[STEPS];
endmodule

>>> sv/fafd_checker.sv
// Port-level checks for the fanning angle block, bound to the top level.
module fafd_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [15:0]  m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata) <= 16'sd25736 &&
                           $signed(m_axis_tdata) >= -16'sd25736))
        else $error("psi out of range");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input taken while output stalled");
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind fanning_angle_from_directions_top fafd_checker u_fafd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);

>>> test/tb_top.sv
// Testbench for the fanning angle pipeline: bit-exact predictor and streaming checks.
`timescale 1ns / 100ps

module tb_top;
    import fafd_pkg::*;

    localparam int STEPS = 16;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        logic               mask;
        logic signed [15:0] fib_x, fib_y, fib_z;
        logic signed [15:0] fan_x, fan_y, fan_z;
    } t_voxel;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [15:0]  m_axis_tdata;
    logic         i_cfg_we = 0;
    logic         i_cfg_idx = 0;
    logic [14:0]  i_cfg_data = '0;

    fanning_angle_from_directions_top #(.CORDIC_STEPS(STEPS)) i_dut (.*);

    t_voxel             voxel_q[$];
    logic signed [15:0] psi_q[$];
    logic [14:0]        axial_thr, azim_thr;
    int                 n_errors = 0;
    int                 cycle = 0;
    bit                 feeding = 0;
    bit                 in_acc = 0, out_acc = 0;
    int                 send_gap = 0, recv_gap = 0;

    initial forever #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (cycle > LIMIT_CYCLES) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // handshakes as seen at the rising edge
    always @(posedge i_clk) begin
        in_acc  <= s_axis_tvalid && s_axis_tready;
        out_acc <= m_axis_tvalid && m_axis_tready;
    end

    function automatic longint asr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint rnd_shr(longint v, int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clamp(longint v, longint lim);
        return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    function automatic longint atan_vec(longint x, longint y);
        longint z = 0, nx, ny;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? longint'(PI_Q29) : -longint'(PI_Q29);
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
            if (y > 0) begin
                nx = x + asr(y, i); ny = y - asr(x, i); z += atan_entry(i);
            end else begin
                nx = x - asr(y, i); ny = y + asr(x, i); z -= atan_entry(i);
            end
            x = nx; y = ny;
        end
        return z;
    endfunction

    task automatic rotate_unit(input longint z, output longint c, output longint s);
        longint x = INV_GAIN, y = 0, nx, ny;
        if (z > HALF_PI_Q29) begin
            x = -x; z -= PI_Q29;
        end else if (z < -HALF_PI_Q29) begin
            x = -x; z += PI_Q29;
        end
        for (int i = 0; i < STEPS && i < TABLE_LEN; i++) begin
            if (z >= 0) begin
                nx = x - asr(y, i); ny = y + asr(x, i); z -= atan_entry(i);
            end else begin
                nx = x + asr(y, i); ny = y - asr(x, i); z += atan_entry(i);
            end
            x = nx; y = ny;
        end
        c = clamp(rnd_shr(x, 14), 32768);
        s = clamp(rnd_shr(y, 14), 32768);
    endtask

    task automatic predict_psi(input t_voxel v, output logic signed [15:0] psi);
        longint t, c, s, phi, m11, m12, m21, m22, b1, b2, det, v1, v2, at;
        if (!v.mask) begin
            psi = 0;
            return;
        end
        t = v.fib_z;
        phi = atan_vec(v.fib_x, v.fib_y);
        rotate_unit(phi, c, s);
        if ((t < 0 ? -t : t) > axial_thr) begin
            m11 = -s; m12 = -rnd_shr(t * c, 15); m21 = c; m22 = -rnd_shr(t * s, 15);
            b1 = v.fan_x; b2 = v.fan_y;
        end else if ((s < 0 ? -s : s) > azim_thr) begin
            m11 = -s; m12 = -rnd_shr(t * c, 15); m21 = 0; m22 = s;
            b1 = v.fan_x; b2 = v.fan_z;
        end else begin
            m11 = c; m12 = -rnd_shr(t * s, 15); m21 = 0; m22 = s;
            b1 = v.fan_y; b2 = v.fan_z;
        end
        det = m11 * m22 - m12 * m21;
        v1 = m22 * b1 - m12 * b2;
        v2 = m11 * b2 - m21 * b1;
        if (det < 0) begin
            v1 = -v1; v2 = -v2;
        end
        at = clamp(rnd_shr(atan_vec(v1, v2), 16), PSI_LIMIT);
        psi = at[15:0];
    endtask

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] exp);
        $display("MISMATCH %s at cycle %0d: got %0d expected %0d",
                 what, cycle, $signed(got), $signed(exp));
        n_errors++;
    endtask

    // driver
    always @(negedge i_clk) begin
        t_voxel v;
        logic signed [15:0] p;
        if (!i_rst_n) begin
            s_axis_tvalid <= 0;
        end else if (s_axis_tvalid && !in_acc) begin
            // word still waiting
        end else if (send_gap > 0) begin
            s_axis_tvalid <= 0;
            send_gap <= send_gap - 1;
        end else if (!feeding || voxel_q.size() == 0) begin
            s_axis_tvalid <= 0;
        end else begin
            v = voxel_q.pop_front();
            predict_psi(v, p);
            psi_q.push_back(p);
            s_axis_tdata <= {7'b0, v.fan_z, v.fan_y, v.fan_x, v.fib_z, v.fib_y, v.fib_x, v.mask};
            s_axis_tvalid <= 1;
            send_gap <= ($urandom_range(0, 9) < 5) ? 0 : int'($urandom_range(0, 11));
        end
    end

    // receiver stall control
    always @(negedge i_clk) begin
        if (recv_gap > 0) begin
            m_axis_tready <= 0;
            recv_gap <= recv_gap - 1;
        end else begin
            m_axis_tready <= 1;
            if (out_acc)
                recv_gap <= ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 11)) : 0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        logic signed [15:0] exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (psi_q.size() == 0) begin
                report("unexpected psi_angle", m_axis_tdata, 16'h0);
            end else begin
                exp = psi_q.pop_front();
                if (m_axis_tdata !== exp) report("psi_angle", m_axis_tdata, exp);
            end
        end
    end

    function automatic logic signed [15:0] pick16();
        case ($urandom_range(0, 5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3: return 16'(int'($urandom_range(0, 4000)) - 2000);
            default: return 16'($urandom());
        endcase
    endfunction

    // random unit-ish fibre direction, sometimes arbitrary
    function automatic t_voxel rand_voxel();
        t_voxel v;
        real ux, uy, uz, n;
        v.mask = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 3) == 0) begin
            v.fib_x = pick16(); v.fib_y = pick16(); v.fib_z = pick16();
        end else begin
            ux = $urandom_range(0, 20000) - 10000.0;
            uy = $urandom_range(0, 20000) - 10000.0;
            uz = $urandom_range(0, 20000) - 10000.0;
            if ($urandom_range(0, 4) == 0) uz = uz / 50.0;
            if ($urandom_range(0, 4) == 0) uy = uy / 50.0;
            n = $sqrt(ux * ux + uy * uy + uz * uz) + 1.0;
            v.fib_x = 16'($rtoi(ux / n * 32767.0));
            v.fib_y = 16'($rtoi(uy / n * 32767.0));
            v.fib_z = 16'($rtoi(uz / n * 32767.0));
        end
        v.fan_x = pick16(); v.fan_y = pick16(); v.fan_z = pick16();
        return v;
    endfunction

    task automatic wait_drained();
        while (voxel_q.size() != 0 || psi_q.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        repeat (3 * STEPS + 20) @(posedge i_clk);
    endtask

    task automatic write_thresholds(input logic [14:0] ax, input logic [14:0] az);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= 1'(REG_AXIAL); i_cfg_data <= ax;
        @(negedge i_clk);
        i_cfg_idx <= 1'(REG_AZIMUTH); i_cfg_data <= az;
        @(negedge i_clk);
        i_cfg_we <= 0;
        axial_thr = ax;
        azim_thr = az;
    endtask

    initial begin
        t_voxel v;
        logic signed [15:0] ext[4] = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
        axial_thr = 15'd3277;
        azim_thr = 15'd3277;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;

        // corners: masked, zero xy, singular, zero fan, field extremes
        v = '{1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
        voxel_q.push_back(v);
        v = '{1'b1, 16'sh0, 16'sh0, 16'sh7fff, 16'sh1000, 16'sh2000, 16'sh3000};
        voxel_q.push_back(v);
        v = '{1'b1, 16'sh0, 16'sh0, 16'sh0, 16'sh1000, 16'sh2000, 16'sh3000};
        voxel_q.push_back(v);
        v = '{1'b1, 16'sh4000, 16'sh4000, 16'sh4000, 16'sh0, 16'sh0, 16'sh0};
        voxel_q.push_back(v);
        v = '{1'b1, 16'sh7fff, 16'sh0, 16'sh0, 16'sh1234, 16'shedcb, 16'sh4000};
        voxel_q.push_back(v);
        v = '{1'b1, 16'sh0, 16'sh7fff, 16'sh0, 16'sh1234, 16'shedcb, 16'sh4000};
        voxel_q.push_back(v);
        v = '{1'b1, 16'sh8000, 16'sh0, 16'sh100, 16'sh7fff, 16'sh8000, 16'sh7fff};
        voxel_q.push_back(v);
        for (int i = 0; i < 16; i++) begin
            v = '{1'b1, ext[i % 4], ext[(i / 4) % 4], ext[(i + 1) % 4],
                  ext[(i + 2) % 4], ext[i / 4], ext[(i + 3) % 4]};
            voxel_q.push_back(v);
        end
        feeding = 1;
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_thresholds(15'd0, 15'd0);
                1: write_thresholds(15'h7fff, 15'h7fff);
                2: write_thresholds(15'd3277, 15'h7fff);
                3: write_thresholds(15'h7fff, 15'd3277);
                default: write_thresholds(15'($urandom_range(0, 32767)),
                                          15'($urandom_range(0, 32767)));
            endcase
            for (int k = 0; k < 300; k++) voxel_q.push_back(rand_voxel());
            wait_drained();
        end

        if (n_errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule
